/* rtl/lsnvs_pkg.sv */
package lsnvs_pkg;

    localparam int NUM_KEYS_DEF       = 8;
    localparam int SLOTS_PER_PAGE_DEF = 64;

    localparam int FUNC_W  = 2;
    localparam int KEY_W   = 8;
    localparam int WORD_W  = 32;
    localparam int SLOT_OW = 6;

    typedef enum logic [FUNC_W-1:0] {
        FN_READ   = 2'd0,
        FN_WRITE  = 2'd1,
        FN_ERASE  = 2'd2,
        FN_UNUSED = 2'd3
    } t_func;

endpackage

/* rtl/lsnvs_ram.sv */
module lsnvs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* rtl/log_structured_nv_store.sv */
// Channel | valid   | stall    | payload
// --------+---------+----------+------------------------------------------------
// input   | i_valid | o_stall  | i_func, i_key, i_write_value, i_default_value
// result  | o_valid | i_stall  | o_read_data, o_found, o_key_bad, o_page_erased,
//         |         |          | o_slot_index
//
// One item at a time: accept, fill-count memory read, value memory read for read hits
// only, then the result register.
// Each key keeps a fill count; the page holds its records in slots 0..count-1, so the
// newest record and the first blank slot come straight from the count, no page scan.
// Synchronous active-low reset clears the count valid bits, so every page reads blank.
// A stalled result waits in the output register while the next item is worked on.
module log_structured_nv_store
    import lsnvs_pkg::*;
#(
    parameter int NUM_KEYS       = NUM_KEYS_DEF,
    parameter int SLOTS_PER_PAGE = SLOTS_PER_PAGE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [FUNC_W-1:0] i_func,
    input  logic [KEY_W-1:0]  i_key,
    input  logic [WORD_W-1:0] i_write_value,
    input  logic [WORD_W-1:0] i_default_value,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [WORD_W-1:0] o_read_data,
    output logic              o_found,
    output logic              o_key_bad,
    output logic              o_page_erased,
    output logic [SLOT_OW-1:0] o_slot_index
);

    localparam int KIDX_W    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int SLOT_W    = $clog2(SLOTS_PER_PAGE);
    localparam int CNT_W     = $clog2(SLOTS_PER_PAGE + 1);
    localparam int CNT_DEPTH = 1 << KIDX_W;
    localparam int VAL_DEPTH = 1 << (KIDX_W + SLOT_W);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_VAL,
        S_OUT
    } t_state;

    t_state               r_state;
    t_func                r_func;
    logic [KEY_W-1:0]     r_key;
    logic [WORD_W-1:0]    r_wval;
    logic [WORD_W-1:0]    r_dval;
    logic [WORD_W-1:0]    r_rdata;
    logic                 r_found;
    logic                 r_bad;
    logic                 r_erased;
    logic [SLOT_W-1:0]    r_slot;
    logic [CNT_DEPTH-1:0] r_cnt_vld;

    logic [KIDX_W-1:0]        kidx;
    logic                     key_ok;
    logic [CNT_W-1:0]         cnt_rdata;
    logic [CNT_W-1:0]         cnt;
    logic [CNT_W-1:0]         cnt_m1;
    logic                     full;
    logic [SLOT_W-1:0]        pick;
    logic                     rd_hit;
    logic                     cnt_we;
    logic [CNT_W-1:0]         cnt_wdata;
    logic                     val_we;
    logic [WORD_W-1:0]        val_rdata;
    logic [SLOT_W+SLOT_OW-1:0] slot_ext;

    assign kidx    = r_key[KIDX_W-1:0];
    assign key_ok  = {1'b0, r_key} < (KEY_W + 1)'(NUM_KEYS);
    assign cnt     = r_cnt_vld[kidx] ? cnt_rdata : '0;
    assign cnt_m1  = cnt - 1'b1;
    assign full    = (cnt == CNT_W'(SLOTS_PER_PAGE));
    assign pick    = full ? '0 : cnt[SLOT_W-1:0];
    assign rd_hit  = (r_func == FN_READ) && key_ok && (cnt != '0);
    assign o_stall = (r_state != S_IDLE);

    // Fill count and value store are written only in the look-up cycle.
    always_comb begin
        cnt_we    = 1'b0;
        val_we    = 1'b0;
        cnt_wdata = '0;
        if (r_state == S_LOOK && key_ok) begin
            if (r_func == FN_WRITE) begin
                cnt_we    = 1'b1;
                val_we    = 1'b1;
                cnt_wdata = full ? CNT_W'(1) : cnt + 1'b1;
            end else if (r_func == FN_ERASE) begin
                cnt_we = 1'b1;
            end
        end
    end

    lsnvs_ram #(
        .WIDTH (CNT_W),
        .DEPTH (CNT_DEPTH)
    ) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (kidx),
        .i_wdata (cnt_wdata),
        .i_raddr (i_key[KIDX_W-1:0]),
        .o_rdata (cnt_rdata)
    );

    lsnvs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (VAL_DEPTH)
    ) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr ({kidx, pick}),
        .i_wdata (r_wval),
        .i_raddr ({kidx, cnt_m1[SLOT_W-1:0]}),
        .o_rdata (val_rdata)
    );

    assign slot_ext = {{SLOT_OW{1'b0}}, r_slot};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt_vld <= '0;
            o_valid   <= 1'b0;
        end else begin
            // drop a delivered beat unless a new one replaces it
            if (o_valid && !i_stall && r_state != S_OUT) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_func  <= t_func'(i_func);
                        r_key   <= i_key;
                        r_wval  <= i_write_value;
                        r_dval  <= i_default_value;
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    r_rdata  <= (r_func == FN_READ) ? r_dval : '0;
                    r_found  <= rd_hit;
                    r_bad    <= (r_func != FN_UNUSED) && !key_ok;
                    r_erased <= key_ok && ((r_func == FN_WRITE && full) ||
                                           r_func == FN_ERASE);
                    r_slot   <= rd_hit ? cnt_m1[SLOT_W-1:0] :
                                (key_ok && r_func == FN_WRITE) ? pick : '0;
                    r_state  <= rd_hit ? S_VAL : S_OUT;
                    if (key_ok && (r_func == FN_WRITE || r_func == FN_ERASE)) begin
                        r_cnt_vld[kidx] <= 1'b1;
                    end
                end
                S_VAL: begin
                    r_rdata <= val_rdata;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // hold until the result register is free
                    if (!o_valid || !i_stall) begin
                        o_valid       <= 1'b1;
                        o_read_data   <= r_rdata;
                        o_found       <= r_found;
                        o_key_bad     <= r_bad;
                        o_page_erased <= r_erased;
                        o_slot_index  <= slot_ext[SLOT_OW-1:0];
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_found_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_found |-> !o_key_bad && !o_page_erased)
        else $error("found record together with bad key or erase");

    a_bad_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_key_bad |-> !o_found && !o_page_erased && o_slot_index == '0)
        else $error("bad key result carries slot, found or erase");

    a_erase_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_page_erased |-> o_read_data == '0)
        else $error("erasing operation returned read data");

    a_look_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_LOOK |-> $past(i_valid) && $past(r_state) == S_IDLE)
        else $error("look-up cycle without an accepted beat");
`endif

endmodule
